// ===== hdl/hufdec_pkg.sv =====
package hufdec_pkg;

  // node table geometry
  localparam int TABLE_NODES = 255;
  localparam int NODE_W      = 8;
  localparam int BRANCH_W    = 16;
  localparam int ENTRY_W     = 2 * BRANCH_W;

  // symbol counter width, input length field width
  localparam int LENGTH_WIDTH = 24;
  localparam int IN_LEN_W     = 24;

  localparam logic [NODE_W-1:0]   HEAD_NODE   = NODE_W'(254);
  localparam logic [BRANCH_W-1:0] LEAF_LIMIT  = BRANCH_W'(256);
  localparam logic [BRANCH_W-1:0] PTR_LIMIT   = BRANCH_W'(256 + TABLE_NODES);

  // operation codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_BYTE  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_LEN = 2'd1;
  localparam logic [1:0] ST_BAD_PTR  = 2'd2;

  typedef logic [LENGTH_WIDTH-1:0] count_t;

  // clamp the requested length to the counter range
  function automatic count_t sat_len(input logic [IN_LEN_W-1:0] len);
    logic [63:0] len_ext;
    logic [63:0] max_ext;
    len_ext = 64'(len);
    max_ext = (64'd1 << LENGTH_WIDTH) - 64'd1;
    if (len_ext > max_ext) begin
      sat_len = count_t'(max_ext);
    end else begin
      sat_len = count_t'(len_ext);
    end
  endfunction

endpackage

// ===== hdl/hufdec_ram.sv =====
module hufdec_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/huffman_tree_byte_decoder.sv =====
// the first symbol of a byte goes through the node read in S_RD and the walk in S_WK, then the output register
// a byte is taken in S_IDLE, its first node is read in S_RD, then S_WK walks up to eight bits
//   (one node-table read per bit, one port); load and start items stay in S_IDLE, zero length passes S_ERR
// no new item is taken outside S_IDLE; an output stall pauses the walk at the next leaf
// reset: rst_n is synchronous, active low; the walk returns to head node 254, no block is
//   active and the output is empty; the node table is not cleared and must be loaded
module huffman_tree_byte_decoder (
  input  logic        clk,
  input  logic        rst_n,
  // input item channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_node_index,
  input  logic [15:0] in_branch_zero,
  input  logic [15:0] in_branch_one,
  input  logic [23:0] in_block_length,
  input  logic [7:0]  in_code_byte,
  // result item channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_symbol,
  output logic        out_block_end,
  output logic [1:0]  out_status
);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;  // take an item
  localparam logic [1:0] S_RD   = 2'd1;  // first node read of a byte
  localparam logic [1:0] S_WK   = 2'd2;  // one bit per cycle through the tree, held at a leaf while the output stalls
  localparam logic [1:0] S_ERR  = 2'd3;  // post a zero-length error item

  localparam logic [2:0] LAST_BIT = 3'd7;

  logic [1:0]                          state_r, state_nxt;
  logic [hufdec_pkg::NODE_W-1:0]       cur_node_r, cur_node_nxt;
  hufdec_pkg::count_t                  left_r, left_nxt;
  logic                                active_r, active_nxt;
  logic [7:0]                          code_r, code_nxt;
  logic [2:0]                          bit_r, bit_nxt;

  // output register
  logic                                out_valid_r, out_valid_nxt;
  logic [7:0]                          out_symbol_r, out_symbol_nxt;
  logic                                out_end_r, out_end_nxt;
  logic [1:0]                          out_status_r, out_status_nxt;

  // node table port
  logic                                ram_we;
  logic                                ram_re;
  logic [hufdec_pkg::NODE_W-1:0]       ram_raddr;
  logic [hufdec_pkg::ENTRY_W-1:0]      ram_rdata;

  logic                                in_acc;
  logic                                out_free;
  logic [hufdec_pkg::BRANCH_W-1:0]     next_w;
  logic                                is_leaf;
  logic                                is_bad;

  hufdec_ram #(
    .WIDTH (hufdec_pkg::ENTRY_W),
    .DEPTH (hufdec_pkg::TABLE_NODES)
  ) u_node_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_node_index),
    .wdata ({in_branch_one, in_branch_zero}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  // output slot can take an item this cycle
  assign out_free = !out_valid_r || !out_stall;

  // branch chosen by the current code bit
  assign next_w  = code_r[bit_r] ? ram_rdata[hufdec_pkg::ENTRY_W-1:hufdec_pkg::BRANCH_W]
                                 : ram_rdata[hufdec_pkg::BRANCH_W-1:0];
  assign is_leaf = next_w < hufdec_pkg::LEAF_LIMIT;
  assign is_bad  = next_w >= hufdec_pkg::PTR_LIMIT;

  always_comb begin
    state_nxt      = state_r;
    cur_node_nxt   = cur_node_r;
    left_nxt       = left_r;
    active_nxt     = active_r;
    code_nxt       = code_r;
    bit_nxt        = bit_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_symbol_nxt = out_symbol_r;
    out_end_nxt    = out_end_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_raddr      = cur_node_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_operation)
            hufdec_pkg::OP_LOAD: begin
              // out-of-range node index is dropped
              ram_we = (in_node_index < 8'(hufdec_pkg::TABLE_NODES));
            end
            hufdec_pkg::OP_START: begin
              cur_node_nxt = hufdec_pkg::HEAD_NODE;
              if (in_block_length == '0) begin
                active_nxt = 1'b0;
                left_nxt   = '0;
                state_nxt  = S_ERR;
              end else begin
                active_nxt = 1'b1;
                left_nxt   = hufdec_pkg::sat_len(in_block_length);
              end
            end
            hufdec_pkg::OP_BYTE: begin
              // bytes outside a block are ignored
              if (active_r) begin
                code_nxt  = in_code_byte;
                bit_nxt   = '0;
                state_nxt = S_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_RD: begin
        ram_re    = 1'b1;
        ram_raddr = cur_node_r;
        state_nxt = S_WK;
      end

      S_WK: begin
        if (is_leaf) begin
          // hold here with the read data intact until the output slot frees up
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_symbol_nxt = next_w[7:0];
            out_status_nxt = hufdec_pkg::ST_OK;
            cur_node_nxt   = hufdec_pkg::HEAD_NODE;
            if (left_r != '0) begin
              left_nxt = left_r - hufdec_pkg::count_t'(1);
            end
            if (left_r <= hufdec_pkg::count_t'(1)) begin
              // block complete: drop the rest of the byte
              out_end_nxt = 1'b1;
              active_nxt  = 1'b0;
              state_nxt   = S_IDLE;
            end else begin
              out_end_nxt = 1'b0;
              if (bit_r == LAST_BIT) begin
                state_nxt = S_IDLE;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = hufdec_pkg::HEAD_NODE;
                bit_nxt   = bit_r + 3'd1;
              end
            end
          end
        end else if (is_bad) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_symbol_nxt = '0;
            out_end_nxt    = 1'b1;
            out_status_nxt = hufdec_pkg::ST_BAD_PTR;
            active_nxt     = 1'b0;
            left_nxt       = '0;
            cur_node_nxt   = hufdec_pkg::HEAD_NODE;
            state_nxt      = S_IDLE;
          end
        end else begin
          // inner node: pointer minus 256 is its low byte
          cur_node_nxt = next_w[7:0];
          if (bit_r == LAST_BIT) begin
            state_nxt = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = next_w[7:0];
            bit_nxt   = bit_r + 3'd1;
          end
        end
      end

      S_ERR: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_symbol_nxt = '0;
          out_end_nxt    = 1'b1;
          out_status_nxt = hufdec_pkg::ST_ZERO_LEN;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_node_r  <= hufdec_pkg::HEAD_NODE;
      left_r      <= '0;
      active_r    <= 1'b0;
      bit_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_node_r  <= cur_node_nxt;
      left_r      <= left_nxt;
      active_r    <= active_nxt;
      bit_r       <= bit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r       <= code_nxt;
    out_symbol_r <= out_symbol_nxt;
    out_end_r    <= out_end_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_symbol    = out_symbol_r;
  assign out_block_end = out_end_r;
  assign out_status    = out_status_r;

  // an error item always closes its block
  a_err_ends_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != hufdec_pkg::ST_OK) |-> out_end_r)
    else $error("error item without block end");

  // an open block always has symbols still to decode
  a_active_count: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (left_r != '0))
    else $error("active block with zero symbols left");

  // the tree walk only runs inside an open block
  a_walk_active: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WK) || (state_r == S_RD) |-> active_r)
    else $error("walk outside an active block");

  // a byte taken inside a block starts a walk
  a_byte_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_operation == hufdec_pkg::OP_BYTE) && active_r |=> (state_r == S_RD))
    else $error("byte in block did not start a walk");

  // the walk never points outside the node table
  a_node_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_node_r < 8'(hufdec_pkg::TABLE_NODES))
    else $error("current node outside the table");

endmodule

// ===== tb/sv/huffman_tree_byte_decoder_tb.sv =====
`timescale 1ns / 1ps

module huffman_tree_byte_decoder_tb;

  // operation code that the block must ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int ITEM_TARGET  = 360;
  localparam int IDLE_PCT     = 18;
  // no idling on either side while the item count is in this window
  localparam int CALM_FROM    = 200;
  localparam int CALM_TO      = 270;
  // long receiver hold-off starts once this many items went in
  localparam int PRESSURE_AT  = 100;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 40;
  localparam int SHOWN_MAX    = 10;

  // how a directed row is checked
  typedef enum logic [1:0] {
    CHK_PREDICT,  // results come from the decode predictor
    CHK_NONE,     // the item gives no result at all
    CHK_ERROR     // one error result: symbol 0, block end, given status
  } check_kind_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  node_index;
    logic [15:0] branch_zero;
    logic [15:0] branch_one;
    logic [23:0] block_length;
    logic [7:0]  code_byte;
  } tree_item_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       block_end;
    logic [1:0] status;
  } symbol_result_t;

  typedef struct packed {
    check_kind_t kind;
    logic [1:0]  operation;
    logic [7:0]  node_index;
    logic [15:0] branch_zero;
    logic [15:0] branch_one;
    logic [23:0] block_length;
    logic [7:0]  code_byte;
    logic [1:0]  err_status;
  } drill_row_t;

  localparam int DRILL_ROWS = 20;

  // directed tree used below:
  //   node 254: bit 0 -> symbol 00, bit 1 -> node 253
  //   node 253: bit 0 -> symbol ff, bit 1 -> node 0
  //   node 0:   bit 0 -> symbol 5a, bit 1 -> node 1
  //   node 1:   bit 0 -> back to head 254 (no symbol), bit 1 -> first bad pointer
  drill_row_t drill_rows [DRILL_ROWS] = '{
    // byte right after reset, no block open: ignored
    '{CHK_NONE, hufdec_pkg::OP_BYTE, 8'd0, 16'h0, 16'h0, 24'd0, 8'hFF, hufdec_pkg::ST_OK},
    // unused operation with every field at all ones: ignored
    '{CHK_NONE, OP_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 8'hFF, hufdec_pkg::ST_OK},
    // zero length request
    '{CHK_ERROR, hufdec_pkg::OP_START, 8'd0, 16'h0, 16'h0, 24'd0, 8'h00,
      hufdec_pkg::ST_ZERO_LEN},
    // load past the end of the table: ignored
    '{CHK_NONE, hufdec_pkg::OP_LOAD, 8'd255, 16'hFFFF, 16'hFFFF, 24'd0, 8'h00, hufdec_pkg::ST_OK},
    '{CHK_NONE, hufdec_pkg::OP_LOAD, 8'd254, 16'h0000, 16'd509, 24'd0, 8'h00, hufdec_pkg::ST_OK},
    '{CHK_NONE, hufdec_pkg::OP_LOAD, 8'd253, 16'h00FF, 16'd256, 24'd0, 8'h00, hufdec_pkg::ST_OK},
    '{CHK_NONE, hufdec_pkg::OP_LOAD, 8'd0, 16'h005A, 16'd257, 24'd0, 8'h00, hufdec_pkg::ST_OK},
    '{CHK_NONE, hufdec_pkg::OP_LOAD, 8'd1, 16'd510, 16'd511, 24'd0, 8'h00, hufdec_pkg::ST_OK},
    // short block cut inside the first byte
    '{CHK_NONE, hufdec_pkg::OP_START, 8'd0, 16'h0, 16'h0, 24'd3, 8'h00, hufdec_pkg::ST_OK},
    '{CHK_PREDICT, hufdec_pkg::OP_BYTE, 8'd0, 16'h0, 16'h0, 24'd0, 8'h00, hufdec_pkg::ST_OK},
    // longest block, then a walk into the bad pointer
    '{CHK_NONE, hufdec_pkg::OP_START, 8'd0, 16'h0, 16'h0, 24'hFFFFFF, 8'h00, hufdec_pkg::ST_OK},
    '{CHK_PREDICT, hufdec_pkg::OP_BYTE, 8'd0, 16'h0, 16'h0, 24'd0, 8'h02, hufdec_pkg::ST_OK},
    '{CHK_ERROR, hufdec_pkg::OP_BYTE, 8'd0, 16'h0, 16'h0, 24'd0, 8'hFF,
      hufdec_pkg::ST_BAD_PTR},
    // block closed by the error: this byte is dropped
    '{CHK_NONE, hufdec_pkg::OP_BYTE, 8'd0, 16'h0, 16'h0, 24'd0, 8'h55, hufdec_pkg::ST_OK},
    // codes that run across byte borders, load in the middle of a walk
    '{CHK_NONE, hufdec_pkg::OP_START, 8'd0, 16'h0, 16'h0, 24'd20, 8'h00, hufdec_pkg::ST_OK},
    '{CHK_PREDICT, hufdec_pkg::OP_BYTE, 8'd0, 16'h0, 16'h0, 24'd0, 8'h80, hufdec_pkg::ST_OK},
    '{CHK_NONE, hufdec_pkg::OP_LOAD, 8'd2, 16'hFFFF, 16'h00FF, 24'd0, 8'h00, hufdec_pkg::ST_OK},
    '{CHK_PREDICT, hufdec_pkg::OP_BYTE, 8'd0, 16'h0, 16'h0, 24'd0, 8'h06, hufdec_pkg::ST_OK},
    '{CHK_PREDICT, hufdec_pkg::OP_BYTE, 8'd0, 16'h0, 16'h0, 24'd0, 8'h07, hufdec_pkg::ST_OK},
    '{CHK_PREDICT, hufdec_pkg::OP_BYTE, 8'd0, 16'h0, 16'h0, 24'd0, 8'h00, hufdec_pkg::ST_OK}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_operation = hufdec_pkg::OP_LOAD;
  logic [7:0]  in_node_index = 8'd0;
  logic [15:0] in_branch_zero = 16'd0;
  logic [15:0] in_branch_one = 16'd0;
  logic [23:0] in_block_length = 24'd0;
  logic [7:0]  in_code_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_symbol;
  logic        out_block_end;
  logic [1:0]  out_status;

  // decode predictor state
  logic [15:0]        tree_zero [hufdec_pkg::TABLE_NODES];
  logic [15:0]        tree_one  [hufdec_pkg::TABLE_NODES];
  logic [7:0]         walk_node = hufdec_pkg::HEAD_NODE;
  hufdec_pkg::count_t symbols_left = '0;
  logic               block_live = 1'b0;

  // symbols still owed by the block, oldest first
  symbol_result_t expected_symbols [$];

  // nodes already written, the only legal pointer targets for stimulus
  bit          node_written [256];
  logic [7:0]  loaded_nodes [$];

  int items_sent = 0;
  int blocks_opened = 0;
  int symbols_checked = 0;
  int error_results = 0;
  int mismatches = 0;
  bit hold_request = 1'b0;
  logic calm;

  assign calm = (items_sent >= CALM_FROM) && (items_sent < CALM_TO);

  huffman_tree_byte_decoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_node_index  (in_node_index),
    .in_branch_zero (in_branch_zero),
    .in_branch_one  (in_branch_one),
    .in_block_length(in_block_length),
    .in_code_byte   (in_code_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_symbol     (out_symbol),
    .out_block_end  (out_block_end),
    .out_status     (out_status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // hard stop in case the block hangs
  initial begin
    #1_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic void push_expected(input bit keep, input logic [7:0] sym,
                                        input logic last, input logic [1:0] st);
    symbol_result_t res;
    res.symbol    = sym;
    res.block_end = last;
    res.status    = st;
    if (keep) begin
      expected_symbols.push_back(res);
    end
  endfunction

  // advance the predictor by one accepted item; keep selects whether the
  // symbols it gives become expectations
  task automatic decode_item(input tree_item_t it, input bit keep);
    logic [15:0] succ;
    int          bit_pos;
    case (it.operation)
      hufdec_pkg::OP_LOAD: begin
        if (it.node_index < hufdec_pkg::TABLE_NODES) begin
          tree_zero[it.node_index] = it.branch_zero;
          tree_one[it.node_index]  = it.branch_one;
        end
      end
      hufdec_pkg::OP_START: begin
        walk_node = hufdec_pkg::HEAD_NODE;
        if (it.block_length == '0) begin
          block_live   = 1'b0;
          symbols_left = '0;
          push_expected(keep, 8'd0, 1'b1, hufdec_pkg::ST_ZERO_LEN);
        end else begin
          symbols_left = it.block_length;
          block_live   = 1'b1;
        end
      end
      hufdec_pkg::OP_BYTE: begin
        // bits lsb first; the walk stops early once the block closes
        bit_pos = 0;
        while (block_live && bit_pos < 8) begin
          succ = it.code_byte[bit_pos] ? tree_one[walk_node] : tree_zero[walk_node];
          if (succ < hufdec_pkg::LEAF_LIMIT) begin
            walk_node = hufdec_pkg::HEAD_NODE;
            if (symbols_left != '0) begin
              symbols_left--;
            end
            block_live = (symbols_left != '0);
            push_expected(keep, succ[7:0], !block_live, hufdec_pkg::ST_OK);
          end else if (succ >= hufdec_pkg::PTR_LIMIT) begin
            block_live   = 1'b0;
            symbols_left = '0;
            walk_node    = hufdec_pkg::HEAD_NODE;
            push_expected(keep, 8'd0, 1'b1, hufdec_pkg::ST_BAD_PTR);
          end else begin
            walk_node = 8'(succ - hufdec_pkg::LEAF_LIMIT);
          end
          bit_pos++;
        end
      end
      default: ;
    endcase
  endtask

  function automatic void mark_loaded(input logic [7:0] idx);
    if (idx < hufdec_pkg::TABLE_NODES && !node_written[idx]) begin
      node_written[idx] = 1'b1;
      loaded_nodes.push_back(idx);
    end
  endfunction

  // mostly leaves and pointers to written nodes, now and then a bad pointer
  function automatic logic [15:0] pick_branch();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 16'($urandom_range(0, 255));
    end else if (r < 97) begin
      return hufdec_pkg::LEAF_LIMIT +
             16'(loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)]);
    end
    return 16'($urandom_range(256 + hufdec_pkg::TABLE_NODES, 65535));
  endfunction

  // every field random, the caller fixes what matters
  function automatic tree_item_t noise_item();
    tree_item_t it;
    it.operation    = 2'($urandom);
    it.node_index   = 8'($urandom);
    it.branch_zero  = 16'($urandom);
    it.branch_one   = 16'($urandom);
    it.block_length = 24'($urandom);
    it.code_byte    = 8'($urandom);
    return it;
  endfunction

  // offer one item, hold it until taken, then record what it should produce
  task automatic send_item(input tree_item_t it, input check_kind_t kind,
                           input logic [1:0] err_status);
    if (items_sent == PRESSURE_AT) begin
      hold_request = 1'b1;
    end
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_operation    <= it.operation;
    in_node_index   <= it.node_index;
    in_branch_zero  <= it.branch_zero;
    in_branch_one   <= it.branch_one;
    in_block_length <= it.block_length;
    in_code_byte    <= it.code_byte;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    items_sent++;
    if (it.operation == hufdec_pkg::OP_START && it.block_length != '0) begin
      blocks_opened++;
    end
    case (kind)
      CHK_PREDICT: decode_item(it, 1'b1);
      CHK_ERROR: begin
        decode_item(it, 1'b0);
        push_expected(1'b1, 8'd0, 1'b1, err_status);
      end
      default: decode_item(it, 1'b0);
    endcase
  endtask

  // one block: maybe reshape the tree, open it, feed bytes, some noise
  task automatic random_block();
    tree_item_t it;
    int         r;
    repeat ($urandom_range(0, 3)) begin
      it = noise_item();
      it.operation = hufdec_pkg::OP_LOAD;
      r = $urandom_range(0, 99);
      if (r < 3) begin
        // out of range index, branches stay fully random
        it.node_index = 8'd255;
      end else begin
        it.node_index = (r < 35) ? hufdec_pkg::HEAD_NODE : 8'($urandom_range(0, 253));
        mark_loaded(it.node_index);
        it.branch_zero = pick_branch();
        it.branch_one  = pick_branch();
      end
      send_item(it, CHK_PREDICT, hufdec_pkg::ST_OK);
    end

    it = noise_item();
    it.operation = hufdec_pkg::OP_START;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      it.block_length = '0;
    end else if (r < 25) begin
      // huge blocks keep running into the next start
      it.block_length = (r < 12) ? 24'($urandom) : 24'($urandom_range(25, 300));
    end else begin
      it.block_length = 24'($urandom_range(1, 24));
    end
    send_item(it, CHK_PREDICT, hufdec_pkg::ST_OK);

    repeat ($urandom_range(1, 6)) begin
      it = noise_item();
      it.operation = hufdec_pkg::OP_BYTE;
      send_item(it, CHK_PREDICT, hufdec_pkg::ST_OK);
    end

    if ($urandom_range(0, 99) < 10) begin
      it = noise_item();
      it.operation = OP_UNUSED;
      send_item(it, CHK_PREDICT, hufdec_pkg::ST_OK);
    end
  endtask

  // result side: random stalls, one long hold-off to back the block up
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // compare every taken symbol with the oldest expectation
  always @(posedge clk) begin : symbol_check
    symbol_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      symbols_checked++;
      if (out_status != hufdec_pkg::ST_OK) begin
        error_results++;
      end
      if (expected_symbols.size() == 0) begin
        if (mismatches < SHOWN_MAX) begin
          $display("unexpected symbol %0h end %0b status %0d",
                   out_symbol, out_block_end, out_status);
        end
        mismatches++;
      end else begin
        want = expected_symbols.pop_front();
        if (out_symbol !== want.symbol || out_block_end !== want.block_end ||
            out_status !== want.status) begin
          if (mismatches < SHOWN_MAX) begin
            $display("mismatch: expected %0h end %0b status %0d, got %0h end %0b status %0d",
                     want.symbol, want.block_end, want.status,
                     out_symbol, out_block_end, out_status);
          end
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    tree_item_t it;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // directed part
    foreach (drill_rows[i]) begin
      it.operation    = drill_rows[i].operation;
      it.node_index   = drill_rows[i].node_index;
      it.branch_zero  = drill_rows[i].branch_zero;
      it.branch_one   = drill_rows[i].branch_one;
      it.block_length = drill_rows[i].block_length;
      it.code_byte    = drill_rows[i].code_byte;
      if (it.operation == hufdec_pkg::OP_LOAD) begin
        mark_loaded(it.node_index);
      end
      send_item(it, drill_rows[i].kind, drill_rows[i].err_status);
    end

    // random blocks on top of the directed tree
    while (items_sent < ITEM_TARGET) begin
      random_block();
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // let the last symbols drain, then give trailing ones time to show up
    while (expected_symbols.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d items sent, %0d blocks opened, %0d tree nodes in use",
             items_sent, blocks_opened, loaded_nodes.size());
    $display("%0d symbols compared, %0d of them error results, %0d mismatches",
             symbols_checked, error_results, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
